[rtl/cpm_pkg.sv]
`default_nettype none

package cpm_pkg;

    localparam int STEP_W   = 20;
    localparam int PHASE_W  = 24;
    localparam int SUM_W    = PHASE_W + 1;
    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [APB_AW-1:0]  apb_addr_t;
    typedef logic [APB_DW-1:0]  apb_data_t;

    localparam logic [2:0] REG_BASE_RED   = 3'd0;
    localparam logic [2:0] REG_BASE_GREEN = 3'd1;
    localparam logic [2:0] REG_BASE_BLUE  = 3'd2;
    localparam logic [2:0] REG_PULSE_MODE = 3'd3;
    localparam logic [2:0] REG_CYCLE_PER  = 3'd4;

    localparam chan_t  CHAN_MAX      = 8'hFF;
    localparam phase_t PERIOD_MIN    = 24'd2;
    localparam phase_t PERIOD_RESET  = 24'd1500000;

endpackage

`default_nettype wire

[rtl/colour_pulse_modulator.sv]
// Channel   | Direction | Handshake       | Payload
// s_        | in        | s_valid/s_ready | s_time_step (20b)
// m_        | out       | m_valid/m_ready | m_out_red/green/blue (8b each), m_cycle_phase (24b)
// apb       | in        | psel/penable    | paddr[4:2] register index, pwdata/prdata 32b
//
// One beat is in flight at a time; a new beat is taken only once the previous result has
// been loaded. The bit-serial datapath runs 25 modulo steps, FRACTION_BITS+1 quotient bits,
// FRACTION_BITS squaring steps and 8 channel multiply steps.
// The result register frees the datapath: a waiting result stalls only the final load.
// Synchronous active-low reset clears control and phase, and loads configuration defaults.
`default_nettype none

module colour_pulse_modulator #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire cpm_pkg::step_t s_time_step,
    output logic                m_valid,
    input  wire                 m_ready,
    output cpm_pkg::chan_t      m_out_red,
    output cpm_pkg::chan_t      m_out_green,
    output cpm_pkg::chan_t      m_out_blue,
    output cpm_pkg::phase_t     m_cycle_phase,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire cpm_pkg::apb_addr_t paddr,
    input  wire cpm_pkg::apb_data_t pwdata,
    output cpm_pkg::apb_data_t  prdata,
    output logic                pready
);

    import cpm_pkg::*;

    localparam int F       = FRACTION_BITS;
    localparam int CNT_MAX = (SUM_W - 1 > F) ? SUM_W - 1 : F;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);

    localparam logic [CNT_W-1:0] CNT_MOD   = CNT_W'(SUM_W - 1);
    localparam logic [CNT_W-1:0] CNT_DIV   = CNT_W'(F);
    localparam logic [CNT_W-1:0] CNT_SQR   = CNT_W'(F - 1);
    localparam logic [CNT_W-1:0] CNT_MUL   = CNT_W'(CHAN_W - 1);
    localparam logic [CNT_W-1:0] CNT_ZERO  = '0;
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    localparam logic [F:0] FRAC_ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F:0] FRAC_HALF = {2'b01, {(F-1){1'b0}}};

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MOD      = 4'd1;
    localparam logic [3:0] ST_HALF     = 4'd2;
    localparam logic [3:0] ST_DIV      = 4'd3;
    localparam logic [3:0] ST_PREP_SQ  = 4'd4;
    localparam logic [3:0] ST_SQR      = 4'd5;
    localparam logic [3:0] ST_PREP_MUL = 4'd6;
    localparam logic [3:0] ST_MUL      = 4'd7;
    localparam logic [3:0] ST_FIN      = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    phase_t           rem_reg, rem_next;
    logic [SUM_W-1:0] dvd_reg, dvd_next;
    phase_t           phase_count_reg, phase_count_next;
    logic             second_reg, second_next;
    logic             lower_reg, lower_next;
    logic [F:0]       t_reg, t_next;
    logic [F-1:0]     sq_mcand_reg, sq_mcand_next;
    logic [F-1:0]     sq_hi_reg, sq_hi_next;
    logic [F-1:0]     sq_lo_reg, sq_lo_next;
    logic [F:0]       f_reg, f_next;
    logic [F:0]       mul_hi_reg [NUM_CHAN];
    logic [F:0]       mul_hi_next [NUM_CHAN];
    chan_t            mul_lo_reg [NUM_CHAN];
    chan_t            mul_lo_next [NUM_CHAN];

    chan_t            base_red_reg, base_red_next;
    chan_t            base_green_reg, base_green_next;
    chan_t            base_blue_reg, base_blue_next;
    logic             pulse_mode_reg, pulse_mode_next;
    phase_t           cycle_period_reg, cycle_period_next;

    logic             m_valid_reg, m_valid_next;
    chan_t            out_red_reg, out_red_next;
    chan_t            out_green_reg, out_green_next;
    chan_t            out_blue_reg, out_blue_next;
    phase_t           cycle_phase_reg, cycle_phase_next;

    phase_t           period;
    logic [SUM_W-1:0] cand;
    logic [SUM_W-1:0] cand_diff;
    logic             cand_ge;
    phase_t           div_rem;
    logic [F:0]       sq_sum;
    logic [F:0]       sq_diff;
    logic [F:0]       ease_q;
    logic [F:0]       ease_cmp;
    logic [F+1:0]     lane_sum [NUM_CHAN];
    logic [F+CHAN_W:0] lane_prod [NUM_CHAN];
    chan_t            lane_floor [NUM_CHAN];
    chan_t            lane_res [NUM_CHAN];
    chan_t            base_arr [NUM_CHAN];
    logic             apb_wr;

    assign base_arr[0] = base_red_reg;
    assign base_arr[1] = base_green_reg;
    assign base_arr[2] = base_blue_reg;

    assign period = (cycle_period_reg < PERIOD_MIN) ? PERIOD_MIN : cycle_period_reg;

    always_comb begin
        case (state_reg)
            ST_MOD:  cand = {rem_reg, dvd_reg[SUM_W-1]};
            ST_HALF: cand = {rem_reg, 1'b0};
            ST_DIV:  cand = (cnt_reg == CNT_DIV) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
            default: cand = '0;
        endcase
    end

    assign cand_ge   = cand >= {1'b0, period};
    assign cand_diff = cand - {1'b0, period};
    assign div_rem   = cand_ge ? cand_diff[PHASE_W-1:0] : cand[PHASE_W-1:0];

    assign sq_sum   = {1'b0, sq_hi_reg} + (sq_lo_reg[0] ? {1'b0, sq_mcand_reg} : '0);
    assign sq_diff  = FRAC_ONE - t_reg;
    assign ease_q   = {sq_hi_reg, sq_lo_reg[F-1]};
    assign ease_cmp = FRAC_ONE - ease_q;

    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            lane_sum[i]   = {1'b0, mul_hi_reg[i]} + (mul_lo_reg[i][0] ? {1'b0, f_reg} : '0);
            lane_prod[i]  = {mul_hi_reg[i], mul_lo_reg[i]};
            lane_floor[i] = lane_prod[i][F+CHAN_W-1:F];
            if (!pulse_mode_reg) begin
                lane_res[i] = lane_floor[i];
            end else if (!second_reg) begin
                lane_res[i] = base_arr[i] + lane_floor[i];
            end else begin
                lane_res[i] = CHAN_MAX - lane_floor[i] - {7'd0, |lane_prod[i][F-1:0]};
            end
        end
    end

    assign apb_wr = psel && penable && pwrite;

    always_comb begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        phase_count_next  = phase_count_reg;
        second_next       = second_reg;
        lower_next        = lower_reg;
        t_next            = t_reg;
        sq_mcand_next     = sq_mcand_reg;
        sq_hi_next        = sq_hi_reg;
        sq_lo_next        = sq_lo_reg;
        f_next            = f_reg;
        for (int i = 0; i < NUM_CHAN; i++) begin
            mul_hi_next[i] = mul_hi_reg[i];
            mul_lo_next[i] = mul_lo_reg[i];
        end
        m_valid_next      = m_valid_reg && !m_ready;
        out_red_next      = out_red_reg;
        out_green_next    = out_green_reg;
        out_blue_next     = out_blue_reg;
        cycle_phase_next  = cycle_phase_reg;
        base_red_next     = base_red_reg;
        base_green_next   = base_green_reg;
        base_blue_next    = base_blue_reg;
        pulse_mode_next   = pulse_mode_reg;
        cycle_period_next = cycle_period_reg;

        if (apb_wr) begin
            case (paddr[4:2])
                REG_BASE_RED:   base_red_next     = pwdata[CHAN_W-1:0];
                REG_BASE_GREEN: base_green_next   = pwdata[CHAN_W-1:0];
                REG_BASE_BLUE:  base_blue_next    = pwdata[CHAN_W-1:0];
                REG_PULSE_MODE: pulse_mode_next   = pwdata[0];
                REG_CYCLE_PER:  cycle_period_next = pwdata[PHASE_W-1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dvd_next   = {1'b0, phase_count_reg} + SUM_W'(s_time_step);
                    rem_next   = '0;
                    cnt_next   = CNT_MOD;
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                rem_next = div_rem;
                dvd_next = {dvd_reg[SUM_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ZERO) begin
                    phase_count_next = div_rem;
                    state_next       = ST_HALF;
                end
            end
            ST_HALF: begin
                second_next = cand_ge && (cand != {1'b0, period});
                rem_next    = (cand_ge && (cand != {1'b0, period})) ?
                              cand_diff[PHASE_W-1:0] : cand[PHASE_W-1:0];
                t_next      = '0;
                cnt_next    = CNT_DIV;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                rem_next = div_rem;
                t_next   = {t_reg[F-1:0], cand_ge};
                cnt_next = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ZERO) begin
                    state_next = ST_PREP_SQ;
                end
            end
            ST_PREP_SQ: begin
                lower_next    = t_reg < FRAC_HALF;
                sq_mcand_next = (t_reg < FRAC_HALF) ? t_reg[F-1:0] : sq_diff[F-1:0];
                sq_lo_next    = (t_reg < FRAC_HALF) ? t_reg[F-1:0] : sq_diff[F-1:0];
                sq_hi_next    = '0;
                cnt_next      = CNT_SQR;
                state_next    = ST_SQR;
            end
            ST_SQR: begin
                sq_hi_next = sq_sum[F:1];
                sq_lo_next = {sq_sum[0], sq_lo_reg[F-1:1]};
                cnt_next   = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ZERO) begin
                    state_next = ST_PREP_MUL;
                end
            end
            ST_PREP_MUL: begin
                f_next = (lower_reg ^ (!pulse_mode_reg && !second_reg)) ? ease_q : ease_cmp;
                for (int i = 0; i < NUM_CHAN; i++) begin
                    mul_hi_next[i] = '0;
                    mul_lo_next[i] = pulse_mode_reg ? (CHAN_MAX - base_arr[i]) : base_arr[i];
                end
                cnt_next   = CNT_MUL;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                for (int i = 0; i < NUM_CHAN; i++) begin
                    mul_hi_next[i] = lane_sum[i][F+1:1];
                    mul_lo_next[i] = {lane_sum[i][0], mul_lo_reg[i][CHAN_W-1:1]};
                end
                cnt_next = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ZERO) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    out_red_next     = lane_res[0];
                    out_green_next   = lane_res[1];
                    out_blue_next    = lane_res[2];
                    cycle_phase_next = phase_count_reg;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            phase_count_reg  <= '0;
            m_valid_reg      <= 1'b0;
            base_red_reg     <= CHAN_MAX;
            base_green_reg   <= CHAN_MAX;
            base_blue_reg    <= CHAN_MAX;
            pulse_mode_reg   <= 1'b0;
            cycle_period_reg <= PERIOD_RESET;
        end else begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            phase_count_reg  <= phase_count_next;
            m_valid_reg      <= m_valid_next;
            base_red_reg     <= base_red_next;
            base_green_reg   <= base_green_next;
            base_blue_reg    <= base_blue_next;
            pulse_mode_reg   <= pulse_mode_next;
            cycle_period_reg <= cycle_period_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg         <= rem_next;
        dvd_reg         <= dvd_next;
        second_reg      <= second_next;
        lower_reg       <= lower_next;
        t_reg           <= t_next;
        sq_mcand_reg    <= sq_mcand_next;
        sq_hi_reg       <= sq_hi_next;
        sq_lo_reg       <= sq_lo_next;
        f_reg           <= f_next;
        for (int i = 0; i < NUM_CHAN; i++) begin
            mul_hi_reg[i] <= mul_hi_next[i];
            mul_lo_reg[i] <= mul_lo_next[i];
        end
        out_red_reg     <= out_red_next;
        out_green_reg   <= out_green_next;
        out_blue_reg    <= out_blue_next;
        cycle_phase_reg <= cycle_phase_next;
    end

    always_comb begin
        case (paddr[4:2])
            REG_BASE_RED:   prdata = APB_DW'(base_red_reg);
            REG_BASE_GREEN: prdata = APB_DW'(base_green_reg);
            REG_BASE_BLUE:  prdata = APB_DW'(base_blue_reg);
            REG_PULSE_MODE: prdata = APB_DW'(pulse_mode_reg);
            REG_CYCLE_PER:  prdata = APB_DW'(cycle_period_reg);
            default:        prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_out_red     = out_red_reg;
    assign m_out_green   = out_green_reg;
    assign m_out_blue    = out_blue_reg;
    assign m_cycle_phase = cycle_phase_reg;

endmodule

`default_nettype wire

[rtl/cpm_checker.sv]
`default_nettype none

module cpm_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input wire                  m_valid,
    input wire                  m_ready,
    input wire cpm_pkg::chan_t  m_out_red,
    input wire cpm_pkg::chan_t  m_out_green,
    input wire cpm_pkg::chan_t  m_out_blue,
    input wire cpm_pkg::phase_t m_cycle_phase
);

    import cpm_pkg::*;

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a beat is in progress");

    a_no_result_right_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared one cycle after input beat");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_out_green)
                               && $stable(m_out_blue) && $stable(m_cycle_phase))
        else $error("stalled result changed");

endmodule

bind colour_pulse_modulator cpm_checker u_cpm_checker (.*);

`default_nettype wire
